// ===== sv/homrep_pkg.sv =====
// Shared widths, limits and register indexes for the homography reprojection block.
package homrep_pkg;

	localparam int CFG_W   = 64;          // config write data width
	localparam int CIDX_W  = 3;           // config index width
	localparam int XW      = 20;          // Q16.4 coordinate width
	localparam int EW      = 21;          // error width, Q17.4
	localparam int PW      = 52;          // 32 x 20 signed product
	localparam int SW      = 54;          // signed sums X, Y, Z
	localparam int MW      = 52;          // magnitudes of X, Y, Z
	localparam int DW      = MW + 3;      // divider remainder, divisor scaled by 8
	localparam int QTW     = 19;          // quotient bits
	localparam int DIFW    = XW + 1;      // coordinate difference
	localparam int SQW     = 2 * DIFW;    // square / root working width
	localparam int DIV_STEPS = QTW;
	localparam int SQ_STEPS  = EW;

	localparam logic signed [XW-1:0] PROJ_MAX = 20'sh7FFFF;
	localparam logic signed [XW-1:0] PROJ_MIN = 20'sh80000;
	localparam logic [EW-1:0]        ERR_MAX  = 21'h1FFFFF;
	localparam logic [XW:0]          Q_HALF_RANGE = 21'h80000;

	localparam logic [CFG_W-1:0] RST_H00_H01 = 64'h0100_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_H02_H10 = 64'h0;
	localparam logic [CFG_W-1:0] RST_H11_H12 = 64'h0100_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_H20_H21 = 64'h0;
	localparam logic [31:0]      RST_H22     = 32'h0100_0000;
	localparam logic [31:0]      RST_DMIN    = 32'h1;

	typedef enum logic [CIDX_W-1:0] {
		REG_H00_H01 = 3'd0,
		REG_H02_H10 = 3'd1,
		REG_H11_H12 = 3'd2,
		REG_H20_H21 = 3'd3,
		REG_H22     = 3'd4,
		REG_DMIN    = 3'd5
	} reg_idx_t;

endpackage

// ===== sv/homography_reprojection_error.sv =====
// Top level: pipelined homography projection and reprojection distance.
//
// One transfer is taken every cycle while the output is not stalled, and results leave in order.
// Stage 1 forms the six 32x20 coefficient products, stage 2 the sums X, Y and Z,
// stage 3 the magnitudes and the shallow-depth test, stage 4 the early saturation
// check. Nineteen restoring divider stages (one quotient bit each) give X/Z and Y/Z
// side by side, a rounding stage saturates to Q16.4, then difference, square and sum
// stages feed twenty-one square-root stages (one result bit each) and the output
// register. The whole pipe holds while the output is stalled; in_stall is high exactly
// then. Items with |Z| below depth_min (or Z of zero) give proj_valid low, zero
// coordinates and the largest error. Config writes take effect at once and must only
// be made while the pipe is empty.
module homography_reprojection_error
	import homrep_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [XW-1:0]    src_x,
	input  logic signed [XW-1:0]    src_y,
	input  logic signed [XW-1:0]    dst_x,
	input  logic signed [XW-1:0]    dst_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [XW-1:0]    proj_x,
	output logic signed [XW-1:0]    proj_y,
	output logic [EW-1:0]           error_dist,
	output logic                    proj_valid
);

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0] h00_h01_q, h02_h10_q, h11_h12_q, h20_h21_q;
	logic [31:0]      h22_q, dmin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h00_h01_q <= RST_H00_H01;
			h02_h10_q <= RST_H02_H10;
			h11_h12_q <= RST_H11_H12;
			h20_h21_q <= RST_H20_H21;
			h22_q     <= RST_H22;
			dmin_q    <= RST_DMIN;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_H00_H01: h00_h01_q <= cfg_data;
				REG_H02_H10: h02_h10_q <= cfg_data;
				REG_H11_H12: h11_h12_q <= cfg_data;
				REG_H20_H21: h20_h21_q <= cfg_data;
				REG_H22:     h22_q     <= cfg_data[31:0];
				REG_DMIN:    dmin_q    <= cfg_data[31:0];
				default: ;   // unknown index, ignored
			endcase
		end
	end

	logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	assign h00 = $signed(h00_h01_q[63:32]);
	assign h01 = $signed(h00_h01_q[31:0]);
	assign h02 = $signed(h02_h10_q[63:32]);
	assign h10 = $signed(h02_h10_q[31:0]);
	assign h11 = $signed(h11_h12_q[63:32]);
	assign h12 = $signed(h11_h12_q[31:0]);
	assign h20 = $signed(h20_h21_q[63:32]);
	assign h21 = $signed(h20_h21_q[31:0]);
	assign h22 = $signed(h22_q);

	// ---------------- flow control ----------------
	// Single hold for the whole pipe: advance when the output slot is free or taken.
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- stage 1: products ----------------
	logic                 v_s1;
	logic signed [PW-1:0] m00_s1, m01_s1, m10_s1, m11_s1, m20_s1, m21_s1;
	logic signed [XW-1:0] u_s1, w_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			m00_s1 <= h00 * src_x;
			m01_s1 <= h01 * src_y;
			m10_s1 <= h10 * src_x;
			m11_s1 <= h11 * src_y;
			m20_s1 <= h20 * src_x;
			m21_s1 <= h21 * src_y;
			u_s1   <= dst_x;
			w_s1   <= dst_y;
		end
	end

	// ---------------- stage 2: X at 2^-28, Y at 2^-28, Z at 2^-40 ----------------
	logic                 v_s2;
	logic signed [SW-1:0] sx_s2, sy_s2, sz_s2;
	logic signed [XW-1:0] u_s2, w_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2 <= SW'(m00_s1) + SW'(m01_s1) + (SW'(h02) <<< 12);
			sy_s2 <= SW'(m10_s1) + SW'(m11_s1) + (SW'(h12) <<< 12);
			sz_s2 <= SW'(m20_s1) + SW'(m21_s1) + (SW'(h22) <<< 16);
			u_s2  <= u_s1;
			w_s2  <= w_s1;
		end
	end

	// ---------------- stage 3: magnitudes, depth test ----------------
	logic signed [SW-1:0] abx, aby, abz;
	assign abx = sx_s2[SW-1] ? -sx_s2 : sx_s2;
	assign aby = sy_s2[SW-1] ? -sy_s2 : sy_s2;
	assign abz = sz_s2[SW-1] ? -sz_s2 : sz_s2;

	logic                 v_s3;
	logic [MW-1:0]        nx_s3, ny_s3, dz_s3;
	logic                 negx_s3, negy_s3, inval_s3;
	logic signed [XW-1:0] u_s3, w_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3    <= abx[MW-1:0];
			ny_s3    <= aby[MW-1:0];
			dz_s3    <= abz[MW-1:0];
			negx_s3  <= sx_s2[SW-1] ^ sz_s2[SW-1];
			negy_s3  <= sy_s2[SW-1] ^ sz_s2[SW-1];
			inval_s3 <= (sz_s2 == '0) || (abz[MW-1:0] < MW'({dmin_q, 16'h0}));
			u_s3     <= u_s2;
			w_s3     <= w_s2;
		end
	end

	// ---------------- stage 4 and divider stages ----------------
	// Divisor scaled by 8 so that the remainder starts below it; each step doubles.
	logic                 dv_s    [0:DIV_STEPS];
	logic [DW-1:0]        drx_s   [0:DIV_STEPS];
	logic [DW-1:0]        dry_s   [0:DIV_STEPS];
	logic [DW-1:0]        dd_s    [0:DIV_STEPS];
	logic [QTW-1:0]       dqx_s   [0:DIV_STEPS];
	logic [QTW-1:0]       dqy_s   [0:DIV_STEPS];
	logic                 dsatx_s [0:DIV_STEPS];
	logic                 dsaty_s [0:DIV_STEPS];
	logic                 dnegx_s [0:DIV_STEPS];
	logic                 dnegy_s [0:DIV_STEPS];
	logic                 dinv_s  [0:DIV_STEPS];
	logic signed [XW-1:0] du_s    [0:DIV_STEPS];
	logic signed [XW-1:0] dw_s    [0:DIV_STEPS];

	logic [DW-1:0] dz8;
	assign dz8 = {dz_s3, 3'b000};

	always_ff @(posedge clk) begin
		if (adv) begin
			drx_s[0]   <= DW'(nx_s3);
			dry_s[0]   <= DW'(ny_s3);
			dd_s[0]    <= dz8;
			dqx_s[0]   <= '0;
			dqy_s[0]   <= '0;
			dsatx_s[0] <= DW'(nx_s3) >= dz8;
			dsaty_s[0] <= DW'(ny_s3) >= dz8;
			dnegx_s[0] <= negx_s3;
			dnegy_s[0] <= negy_s3;
			dinv_s[0]  <= inval_s3;
			du_s[0]    <= u_s3;
			dw_s[0]    <= w_s3;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DW:0] tx, ty;
		logic        bx, by;
		assign tx = {drx_s[k], 1'b0};
		assign ty = {dry_s[k], 1'b0};
		assign bx = tx >= {1'b0, dd_s[k]};
		assign by = ty >= {1'b0, dd_s[k]};

		always_ff @(posedge clk) begin
			if (adv) begin
				drx_s[k+1]   <= bx ? DW'(tx - {1'b0, dd_s[k]}) : DW'(tx);
				dry_s[k+1]   <= by ? DW'(ty - {1'b0, dd_s[k]}) : DW'(ty);
				dqx_s[k+1]   <= {dqx_s[k][QTW-2:0], bx};
				dqy_s[k+1]   <= {dqy_s[k][QTW-2:0], by};
				dd_s[k+1]    <= dd_s[k];
				dsatx_s[k+1] <= dsatx_s[k];
				dsaty_s[k+1] <= dsaty_s[k];
				dnegx_s[k+1] <= dnegx_s[k];
				dnegy_s[k+1] <= dnegy_s[k];
				dinv_s[k+1]  <= dinv_s[k];
				du_s[k+1]    <= du_s[k];
				dw_s[k+1]    <= dw_s[k];
			end
		end
	end

	// ---------------- rounding and saturation ----------------
	localparam int DL = DIV_STEPS;

	logic          rndx, rndy;
	logic [XW:0]   qrx, qry;
	assign rndx = {drx_s[DL], 1'b0} >= {1'b0, dd_s[DL]};
	assign rndy = {dry_s[DL], 1'b0} >= {1'b0, dd_s[DL]};
	assign qrx  = (XW+1)'(dqx_s[DL]) + (XW+1)'(rndx);
	assign qry  = (XW+1)'(dqy_s[DL]) + (XW+1)'(rndy);

	function automatic logic signed [XW-1:0] sat_proj(input logic sat, input logic neg,
			input logic [XW:0] q);
		logic signed [XW:0] nq;
		nq = -$signed(q);
		if (sat)
			sat_proj = neg ? PROJ_MIN : PROJ_MAX;
		else if (neg)
			sat_proj = (q > Q_HALF_RANGE) ? PROJ_MIN : nq[XW-1:0];
		else
			sat_proj = (q >= Q_HALF_RANGE) ? PROJ_MAX : $signed(q[XW-1:0]);
	endfunction

	logic                 v_r;
	logic signed [XW-1:0] px_r, py_r, u_r, w_r;
	logic                 inv_r;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_r  <= dinv_s[DL] ? '0 : sat_proj(dsatx_s[DL], dnegx_s[DL], qrx);
			py_r  <= dinv_s[DL] ? '0 : sat_proj(dsaty_s[DL], dnegy_s[DL], qry);
			inv_r <= dinv_s[DL];
			u_r   <= du_s[DL];
			w_r   <= dw_s[DL];
		end
	end

	// ---------------- differences, squares, sum ----------------
	logic                   v_f, v_q, v_m;
	logic signed [DIFW-1:0] dx_f, dy_f;
	logic signed [XW-1:0]   px_f, py_f, px_q, py_q, px_m, py_m;
	logic                   inv_f, inv_q, inv_m;
	logic signed [SQW-1:0]  qx_q, qy_q;
	logic [SQW-1:0]         d2_m;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_f  <= DIFW'(px_r) - DIFW'(u_r);
			dy_f  <= DIFW'(py_r) - DIFW'(w_r);
			px_f  <= px_r;
			py_f  <= py_r;
			inv_f <= inv_r;
			qx_q  <= dx_f * dx_f;
			qy_q  <= dy_f * dy_f;
			px_q  <= px_f;
			py_q  <= py_f;
			inv_q <= inv_f;
			d2_m  <= $unsigned(qx_q) + $unsigned(qy_q);
			px_m  <= px_q;
			py_m  <= py_q;
			inv_m <= inv_q;
		end
	end

	// ---------------- square root stages ----------------
	logic                 rv_s   [0:SQ_STEPS];
	logic [SQW-1:0]       rn_s   [0:SQ_STEPS];
	logic [SQW-1:0]       rr_s   [0:SQ_STEPS];
	logic signed [XW-1:0] rpx_s  [0:SQ_STEPS];
	logic signed [XW-1:0] rpy_s  [0:SQ_STEPS];
	logic                 rinv_s [0:SQ_STEPS];

	assign rv_s[0]   = v_m;
	assign rn_s[0]   = d2_m;
	assign rr_s[0]   = '0;
	assign rpx_s[0]  = px_m;
	assign rpy_s[0]  = py_m;
	assign rinv_s[0] = inv_m;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQW-1:0] trial;
		logic           take;
		assign trial = rr_s[k] + BITV;
		assign take  = rn_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rn_s[k+1]   <= take ? rn_s[k] - trial : rn_s[k];
				rr_s[k+1]   <= take ? (rr_s[k] >> 1) + BITV : rr_s[k] >> 1;
				rpx_s[k+1]  <= rpx_s[k];
				rpy_s[k+1]  <= rpy_s[k];
				rinv_s[k+1] <= rinv_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k+1] <= 1'b0;
			end else if (adv) begin
				rv_s[k+1] <= rv_s[k];
			end
		end
	end

	// ---------------- output register ----------------
	localparam int RL = SQ_STEPS;

	logic [SQW-1:0] root;
	assign root = rr_s[RL] + SQW'(rn_s[RL] > rr_s[RL]);

	always_ff @(posedge clk) begin
		if (adv) begin
			proj_x     <= rpx_s[RL];
			proj_y     <= rpy_s[RL];
			proj_valid <= !rinv_s[RL];
			if (rinv_s[RL] || root > SQW'(ERR_MAX))
				error_dist <= ERR_MAX;
			else
				error_dist <= root[EW-1:0];
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_r       <= 1'b0;
			v_f       <= 1'b0;
			v_q       <= 1'b0;
			v_m       <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_r       <= dv_s[DL];
			v_f       <= v_r;
			v_q       <= v_f;
			v_m       <= v_q;
			out_valid <= rv_s[RL];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= v_s3;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_s[k+1] <= dv_s[k];
			end
		end
	end

	// ---------------- assertions ----------------
	// An invalid result carries zero coordinates and the largest error.
	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !proj_valid |-> error_dist == ERR_MAX && proj_x == '0 && proj_y == '0)
		else $error("invalid result not in its fixed form");

	// An accepted transfer enters stage one.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transfer lost at entry");

	// A stalled pipe moves neither its last divider stage nor its last square-root stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(dv_s[DL]) && $stable(rv_s[RL]))
		else $error("pipe moved while held");

	// For an unsaturated item, the remainder left by the divider stays below the scaled divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s[DL] && !dsatx_s[DL] |-> drx_s[DL] < dd_s[DL])
		else $error("divider remainder out of range");

endmodule
